### src/ghu_pkg.sv
// ghu_pkg: types, constants and helpers shared by the GHASH block update unit.
// No dependencies.
`timescale 1ns / 1ps

package ghu_pkg;

   localparam int unsigned BLOCK_W   = 128;
   localparam int unsigned HALF_W    = 64;
   localparam int unsigned DIGIT_W   = 4;
   localparam int unsigned NUM_DIGIT = BLOCK_W / DIGIT_W;
   localparam int unsigned CNT_W     = $clog2(NUM_DIGIT);
   localparam int unsigned VB_W      = 5;
   localparam int unsigned CSR_IDX_W = 2;

   // reduction constant for x^128 + x^7 + x^2 + x + 1 in reflected order
   localparam logic [BLOCK_W-1:0] RED_POLY = {8'he1, 120'd0};

   localparam logic [CSR_IDX_W-1:0] CSR_KEY_HI = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_LO = 2'd1;

   typedef logic [BLOCK_W-1:0] block_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_HOLD
   } state_type;

   // zero every byte at or past the valid count; byte 0 is the top byte
   function automatic block_type mask_bytes(block_type data, logic [VB_W-1:0] nbytes);
      block_type res;
      res = data;
      for (int i = 0; i < 16; i++) begin
         if (nbytes <= VB_W'(i)) begin
            res[BLOCK_W-1-8*i -: 8] = 8'd0;
         end
      end
      return res;
   endfunction

endpackage

### src/ghu_gfmul.sv
// ghu_gfmul: digit-serial GF(2^128) multiplier in GCM bit order, 4 bits of X per cycle.
// Depends on ghu_pkg.
`timescale 1ns / 1ps

module ghu_gfmul (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  ghu_pkg::block_type x_in,
   input  ghu_pkg::block_type h_in,
   output ghu_pkg::block_type prod,
   output logic               done
);

   ghu_pkg::block_type x_ff, x_in_nx;
   ghu_pkg::block_type v_ff, v_in;
   ghu_pkg::block_type z_ff, z_in;
   logic [ghu_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic run_ff, run_in;

   // one digit: four shift-and-add steps, top bit of x first
   always_comb begin
      ghu_pkg::block_type zv;
      ghu_pkg::block_type vv;
      zv = z_ff;
      vv = v_ff;
      for (int j = 0; j < ghu_pkg::DIGIT_W; j++) begin
         if (x_ff[ghu_pkg::BLOCK_W-1-j]) begin
            zv = zv ^ vv;
         end
         if (vv[0]) begin
            vv = (vv >> 1) ^ ghu_pkg::RED_POLY;
         end else begin
            vv = vv >> 1;
         end
      end
      z_in    = zv;
      v_in    = vv;
      x_in_nx = x_ff << ghu_pkg::DIGIT_W;
      cnt_in  = cnt_ff + 1'b1;
      run_in  = run_ff;
      if (run_ff && (cnt_ff == ghu_pkg::CNT_W'(ghu_pkg::NUM_DIGIT - 1))) begin
         run_in = 1'b0;
      end
      if (start) begin
         z_in    = '0;
         v_in    = h_in;
         x_in_nx = x_in;
         cnt_in  = '0;
         run_in  = 1'b1;
      end
   end

   assign done = run_ff && (cnt_ff == ghu_pkg::CNT_W'(ghu_pkg::NUM_DIGIT - 1));
   assign prod = z_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         run_ff <= run_in;
         cnt_ff <= cnt_in;
      end
      x_ff <= x_in_nx;
      v_ff <= v_in;
      z_ff <= z_in;
   end

   assert property (@(posedge clock) disable iff (reset) start |=> run_ff && cnt_ff == '0)
      else $error("multiplier did not start");
   assert property (@(posedge clock) disable iff (reset) done |=> !run_ff || start)
      else $error("multiplier ran past last digit");
   assert property (@(posedge clock) disable iff (reset) run_ff && !done |=> run_ff)
      else $error("multiplier stopped early");

endmodule

### src/ghash_block_update_unit.sv
// ghash_block_update_unit: GHASH accumulator Y = (Y xor X) * H for AES-GCM.
// Depends on ghu_pkg and ghu_gfmul.
//
// Usage:
//  - csr channel: csr_index 0 writes H bytes 0..7, index 1 writes bytes 8..15.
//    csr_ready is always high; write only while the unit is idle.
//  - req channel: one 128-bit block per word, bytes past req_valid_bytes read
//    as zero (counts above 16 mean all 16). req_first clears Y before the block.
//  - rsp channel: one word per request carrying the updated Y.
//  - Each block runs through the multiplier one 4-bit digit of X per
//    cycle; the product is registered into the output at the edge that ends
//    the last digit unless the output is stalled. req_stall stays high until
//    the product has left the multiplier, so blocks never overlap there.
//  - A new block may be accepted while the previous result still waits on
//    rsp_stall. If the next product finishes while the output is stalled,
//    the unit holds it and keeps req_stall high until the output drains.
//  - Reset (synchronous) clears Y, H and all handshake state; req_stall is
//    high while reset is asserted.
`timescale 1ns / 1ps

module ghash_block_update_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [ghu_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ghu_pkg::HALF_W-1:0]       csr_wdata,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [ghu_pkg::HALF_W-1:0]       req_data_hi,
   input  logic [ghu_pkg::HALF_W-1:0]       req_data_lo,
   input  logic [ghu_pkg::VB_W-1:0]         req_valid_bytes,
   input  logic                             req_first,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [ghu_pkg::HALF_W-1:0]       rsp_hash_hi,
   output logic [ghu_pkg::HALF_W-1:0]       rsp_hash_lo
);

   ghu_pkg::state_type state_ff, state_in;
   ghu_pkg::block_type acc_ff, acc_in;
   ghu_pkg::block_type key_ff, key_in;
   ghu_pkg::block_type out_ff, out_in;
   logic rsp_valid_ff, rsp_valid_in;

   ghu_pkg::block_type mul_x;
   ghu_pkg::block_type mul_prod;
   logic mul_start, mul_done, req_take;

   assign csr_ready = 1'b1;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      key_in = key_ff;
      if (csr_valid && csr_index == ghu_pkg::CSR_KEY_HI) begin
         key_in[ghu_pkg::BLOCK_W-1 -: ghu_pkg::HALF_W] = csr_wdata;
      end
      if (csr_valid && csr_index == ghu_pkg::CSR_KEY_LO) begin
         key_in[ghu_pkg::HALF_W-1:0] = csr_wdata;
      end
   end

   always_comb begin
      mul_x = ghu_pkg::mask_bytes({req_data_hi, req_data_lo}, req_valid_bytes);
      if (!req_first) begin
         mul_x = mul_x ^ acc_ff;
      end
   end

   always_comb begin
      state_in     = state_ff;
      acc_in       = acc_ff;
      out_in       = out_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      mul_start    = 1'b0;
      req_stall    = 1'b1;
      case (state_ff)
         ghu_pkg::ST_IDLE: begin
            req_stall = reset;
            if (req_valid && !reset) begin
               mul_start = 1'b1;
               state_in  = ghu_pkg::ST_RUN;
            end
         end
         ghu_pkg::ST_RUN: begin
            if (mul_done) begin
               acc_in = mul_prod;
               if (!rsp_valid_ff || !rsp_stall) begin
                  out_in       = mul_prod;
                  rsp_valid_in = 1'b1;
                  state_in     = ghu_pkg::ST_IDLE;
               end else begin
                  state_in = ghu_pkg::ST_HOLD;
               end
            end
         end
         ghu_pkg::ST_HOLD: begin
            if (!rsp_stall) begin
               out_in       = acc_ff;
               rsp_valid_in = 1'b1;
               state_in     = ghu_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ghu_pkg::ST_IDLE;
         end
      endcase
   end

   ghu_gfmul u_gfmul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .x_in  (mul_x),
      .h_in  (key_ff),
      .prod  (mul_prod),
      .done  (mul_done)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ghu_pkg::ST_IDLE;
         acc_ff       <= '0;
         key_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         key_ff       <= key_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      out_ff <= out_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_hash_hi = out_ff[ghu_pkg::BLOCK_W-1 -: ghu_pkg::HALF_W];
   assign rsp_hash_lo = out_ff[ghu_pkg::HALF_W-1:0];

   assert property (@(posedge clock) disable iff (reset)
      req_take |=> state_ff == ghu_pkg::ST_RUN)
      else $error("accepted word did not start the multiply");
   assert property (@(posedge clock) disable iff (reset)
      mul_done |-> state_ff == ghu_pkg::ST_RUN)
      else $error("multiplier finished outside run state");
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ghu_pkg::ST_HOLD |-> rsp_valid_ff)
      else $error("holding a result with an empty output");
   assert property (@(posedge clock) disable iff (reset)
      mul_done && state_ff == ghu_pkg::ST_RUN |=> acc_ff == $past(mul_prod))
      else $error("accumulator not updated with product");

endmodule
